@@ sv/sfip_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shared types and constants for the sorted free identifier pool.
package sfip_pkg;

  // Pool geometry. At most DEPTH-1 identifiers are held at any time.
  localparam int unsigned DEPTH    = 64;
  localparam int unsigned ID_WIDTH = 16;
  localparam int unsigned IDX_W    = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  // Fixed widths of the transaction fields.
  localparam int unsigned ID_IO_W     = 16;
  localparam int unsigned COUNT_OUT_W = 6;

  // Largest entry count the pool may hold.
  localparam logic [IDX_W-1:0] COUNT_MAX = IDX_W'(DEPTH - 1);

  typedef enum logic {
    FUNC_RELEASE  = 1'b0,
    FUNC_ALLOCATE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_REM_HEAD,
    S_REM_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [ID_IO_W-1:0] id_in;
  } in_t;

  typedef struct packed {
    status_e                status;
    logic [ID_IO_W-1:0]     id_out;
    logic [COUNT_OUT_W-1:0] count;
  } out_t;

  // Request from the sequencer to the entry store.
  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [ID_WIDTH-1:0] wdata;
    logic [IDX_W-1:0]    raddr;
  } mem_req_t;

endpackage

`default_nettype wire

@@ sv/sfip_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Entry store: one write port and one read port with registered read data.
module sfip_mem (
  input  wire logic                             clk_i,
  input  wire sfip_pkg::mem_req_t               req_i,
  output logic [sfip_pkg::ID_WIDTH-1:0]         rdata_o
);

  logic [sfip_pkg::ID_WIDTH-1:0] mem_q [sfip_pkg::DEPTH];
  logic [sfip_pkg::ID_WIDTH-1:0] rdata_q;

  // Write and read both happen at the clock edge.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/sorted_free_id_pool_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sequencing: a release moves up the held entries not below the new identifier, then writes
// it; an allocate reads the smallest entry and moves the rest down one place; full and empty
// results skip the walk. An output stall holds the finished result in the done state.
// Throughput: one transaction at a time, set by the walk over the store, one entry per cycle;
// the next transaction is accepted once the result has gone on and the sequencer is idle.
// Reset: asynchronous, active low; clears the entry count and control state.

module sorted_free_id_pool_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire sfip_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output sfip_pkg::out_t      out_data_o
);

  sfip_pkg::state_e                  state_q, state_d;
  logic [sfip_pkg::IDX_W-1:0]        j_q, j_d;
  logic [sfip_pkg::IDX_W-1:0]        count_q, count_d;
  logic [sfip_pkg::ID_WIDTH-1:0]     id_q, id_d;
  logic [sfip_pkg::ID_WIDTH-1:0]     res_q, res_d;
  sfip_pkg::func_e                   func_q, func_d;
  sfip_pkg::status_e                 status_q, status_d;
  logic                              out_valid_q, out_valid_d;
  sfip_pkg::out_t                    out_q, out_d;
  sfip_pkg::mem_req_t                req;
  logic [sfip_pkg::ID_WIDTH-1:0]     rdata;
  logic                              out_free;

  sfip_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer: walks the sorted store one entry per cycle.
  always_comb begin
    state_d     = state_q;
    j_d         = j_q;
    count_d     = count_q;
    id_d        = id_q;
    res_d       = res_q;
    func_d      = func_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    req         = '0;

    // The output register drains independently of the sequencer.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      sfip_pkg::S_IDLE: begin
        if (in_valid_i) begin
          id_d     = sfip_pkg::ID_WIDTH'(in_data_i.id_in);
          func_d   = in_data_i.func;
          res_d    = '0;
          status_d = sfip_pkg::STATUS_OK;
          if (in_data_i.func == sfip_pkg::FUNC_RELEASE) begin
            if (count_q == sfip_pkg::COUNT_MAX) begin
              status_d = sfip_pkg::STATUS_FULL;
              state_d  = sfip_pkg::S_DONE;
            end else begin
              // Start at the top and read the last held entry.
              j_d       = count_q;
              req.raddr = (count_q != '0) ? count_q - sfip_pkg::IDX_W'(1) : '0;
              state_d   = sfip_pkg::S_INSERT;
            end
          end else begin
            if (count_q == '0) begin
              status_d = sfip_pkg::STATUS_EMPTY;
              state_d  = sfip_pkg::S_DONE;
            end else begin
              req.raddr = '0;
              state_d   = sfip_pkg::S_REM_HEAD;
            end
          end
        end
      end

      sfip_pkg::S_INSERT: begin
        // rdata holds entry j-1; larger or equal entries move up one place.
        req.we    = 1'b1;
        req.waddr = j_q;
        if (j_q != '0 && rdata >= id_q) begin
          req.wdata = rdata;
          j_d       = j_q - sfip_pkg::IDX_W'(1);
          req.raddr = (j_q >= sfip_pkg::IDX_W'(2)) ? j_q - sfip_pkg::IDX_W'(2) : '0;
        end else begin
          req.wdata = id_q;
          state_d   = sfip_pkg::S_DONE;
        end
      end

      sfip_pkg::S_REM_HEAD: begin
        // rdata holds the smallest entry.
        res_d = rdata;
        if (count_q == sfip_pkg::IDX_W'(1)) begin
          state_d = sfip_pkg::S_DONE;
        end else begin
          j_d       = sfip_pkg::IDX_W'(1);
          req.raddr = sfip_pkg::IDX_W'(1);
          state_d   = sfip_pkg::S_REM_SHIFT;
        end
      end

      sfip_pkg::S_REM_SHIFT: begin
        // rdata holds entry j; it moves down one place.
        req.we    = 1'b1;
        req.waddr = j_q - sfip_pkg::IDX_W'(1);
        req.wdata = rdata;
        if (j_q == count_q - sfip_pkg::IDX_W'(1)) begin
          state_d = sfip_pkg::S_DONE;
        end else begin
          j_d       = j_q + sfip_pkg::IDX_W'(1);
          req.raddr = j_q + sfip_pkg::IDX_W'(1);
        end
      end

      sfip_pkg::S_DONE: begin
        // Commit the count and hand the transaction to the output register.
        if (out_free) begin
          if (status_q == sfip_pkg::STATUS_OK) begin
            if (func_q == sfip_pkg::FUNC_RELEASE) begin
              count_d = count_q + sfip_pkg::IDX_W'(1);
            end else begin
              count_d = count_q - sfip_pkg::IDX_W'(1);
            end
          end
          out_d.status = status_q;
          out_d.id_out = sfip_pkg::ID_IO_W'(res_q);
          out_d.count  = sfip_pkg::COUNT_OUT_W'(count_d);
          out_valid_d  = 1'b1;
          state_d      = sfip_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = sfip_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfip_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    j_q      <= j_d;
    id_q     <= id_d;
    res_q    <= res_d;
    func_q   <= func_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != sfip_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The store is never written above the current fill level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.we |-> req.waddr <= count_q)
    else $error("store write beyond fill level");

  // A refused release reports a full pool.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == sfip_pkg::STATUS_FULL) |->
      out_data_o.count == sfip_pkg::COUNT_OUT_W'(sfip_pkg::COUNT_MAX))
    else $error("full status with wrong count");

  // An empty allocate reports zero identifier and zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == sfip_pkg::STATUS_EMPTY) |->
      (out_data_o.count == '0 && out_data_o.id_out == '0))
    else $error("empty status with nonzero payload");

  // The entry count changes by at most one per transaction and only when finishing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(state_q) == sfip_pkg::S_DONE)
    else $error("entry count changed outside completion");

endmodule

`default_nettype wire

@@ test/sorted_free_id_pool_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the free identifier pool, predicts every result
// from its own copy of the sorted pool and compares field by field.
module sorted_free_id_pool_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  sfip_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  sfip_pkg::out_t out_data_i,
  output int             fail_count_o,
  output int             pending_o
);
  import sfip_pkg::*;

  // Beyond this many reports, mismatches are only counted.
  localparam int MAX_REPORTS = 100;

  // Held identifiers in ascending order, and the results still owed.
  logic [ID_WIDTH-1:0] free_ids[$];
  out_t                results_due[$];
  int                  mismatches = 0;
  int                  waiting    = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  // Applies one transaction to the predicted pool and returns its result.
  function automatic out_t pool_step(input in_t item);
    out_t                res;
    logic [ID_WIDTH-1:0] id;
    int                  pos;
    res.status = STATUS_OK;
    res.id_out = '0;
    id = ID_WIDTH'(item.id_in);
    if (item.func == FUNC_RELEASE) begin
      // The pool refuses an insert that would bring it to DEPTH entries.
      if (free_ids.size() + 1 < DEPTH) begin
        // A new value goes in front of any equal entries.
        pos = 0;
        while (pos < free_ids.size() && free_ids[pos] < id) pos++;
        free_ids.insert(pos, id);
      end else begin
        res.status = STATUS_FULL;
      end
    end else if (free_ids.size() > 0) begin
      res.id_out = ID_IO_W'(free_ids.pop_front());
    end else begin
      res.status = STATUS_EMPTY;
    end
    res.count = COUNT_OUT_W'(free_ids.size());
    return res;
  endfunction

  task automatic report(input string field, input logic [31:0] want_v,
                        input logic [31:0] got_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $error("%s mismatch: expected %0d, actual %0d", field, want_v, got_v);
  endtask

  // Results are checked before the new transaction is predicted, since a
  // result always belongs to an older transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      free_ids.delete();
      results_due.delete();
      waiting <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $error("unexpected result: status %0d, id_out %0d, count %0d",
                   out_data_i.status, out_data_i.id_out, out_data_i.count);
        end else begin
          want = results_due.pop_front();
          if (out_data_i.status !== want.status)
            report("status", 32'(want.status), 32'(out_data_i.status));
          if (out_data_i.id_out !== want.id_out)
            report("id_out", 32'(want.id_out), 32'(out_data_i.id_out));
          if (out_data_i.count !== want.count)
            report("count", 32'(want.count), 32'(out_data_i.count));
        end
      end
      if (in_valid_i && !in_stall_i) results_due.push_back(pool_step(in_data_i));
      waiting <= results_due.size();
    end
  end

endmodule

@@ test/sorted_free_id_pool_core_tb.sv @@
`timescale 1ns / 1ps

module sorted_free_id_pool_core_tb;
  import sfip_pkg::*;

  localparam int RANDOM_ITEMS  = 1530;
  localparam int PHASE_LEN     = 85;
  localparam int CALM_TAIL     = 150;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 10;
  localparam int STUCK_LIMIT   = 4000;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_data;

  // Shared between the sender and the receiver.
  logic wind_down = 1'b0;
  logic hold_req  = 1'b0;

  int stuck_cycles = 0;
  int fail_count;
  int pending;

  always #5 clk = ~clk;

  sorted_free_id_pool_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  sorted_free_id_pool_checker pool_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Offers one transaction and returns at the edge that accepts it.
  task automatic send(input func_e f, input logic [ID_IO_W-1:0] id);
    in_valid <= 1'b1;
    in_data  <= '{func: f, id_in: id};
    do @(posedge clk); while (in_stall);
  endtask

  // With one chance in odds, the sender goes quiet for a short burst.
  task automatic idle_gap(input int odds);
    if (!wind_down && odds > 0 && $urandom_range(1, odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Stops offering until every owed result has come back.
  task automatic drain_wait();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // Mostly full-range values, with extremes and a narrow band for duplicates.
  function automatic logic [ID_IO_W-1:0] pick_id();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return ID_IO_W'($urandom_range(0, 7));
      default: return ID_IO_W'($urandom);
    endcase
  endfunction

  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  initial begin : receiver
    @(posedge clk);
    forever begin
      if (wind_down) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end
    end
  end

  // Sender: directed transactions, then biased random phases, then the verdict.
  initial begin : stimulus
    int    release_pct;
    int    gap_odds;
    func_e f;
    release_pct = 50;
    gap_odds    = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Allocate from an empty pool.
    send(FUNC_ALLOCATE, 16'h0000);
    // Extremes, an equal pair and alternating bit patterns, out of order.
    send(FUNC_RELEASE, 16'hFFFF);
    send(FUNC_RELEASE, 16'h0000);
    send(FUNC_RELEASE, 16'h8000);
    send(FUNC_RELEASE, 16'h8000);
    send(FUNC_RELEASE, 16'h7FFF);
    send(FUNC_RELEASE, 16'h0001);
    send(FUNC_RELEASE, 16'hAAAA);
    send(FUNC_RELEASE, 16'h5555);
    // Drain in ascending order; the identifier field is ignored here.
    send(FUNC_ALLOCATE, 16'hFFFF);
    send(FUNC_ALLOCATE, 16'h1234);
    send(FUNC_ALLOCATE, 16'h0000);
    send(FUNC_ALLOCATE, 16'h5555);
    send(FUNC_ALLOCATE, 16'hAAAA);
    send(FUNC_ALLOCATE, 16'h0000);
    send(FUNC_ALLOCATE, 16'hFFFF);
    send(FUNC_ALLOCATE, 16'h0000);
    // Empty again after the last entry left.
    send(FUNC_ALLOCATE, 16'h0000);
    send(FUNC_RELEASE, 16'h1234);
    send(FUNC_ALLOCATE, 16'h0000);

    // Phases alternate between filling to the full limit, draining to empty
    // and a balanced mix, so both boundaries are hit many times.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ((n / PHASE_LEN) % 3)
          0:       release_pct = 90;
          1:       release_pct = 20;
          default: release_pct = 50;
        endcase
        gap_odds = ((n / PHASE_LEN) % 4 == 3) ? 0 : 5;
        if ((n / PHASE_LEN) % 5 == 4) drain_wait();
      end
      if (n == 400) hold_req = 1'b1;
      if (n == RANDOM_ITEMS - CALM_TAIL) wind_down = 1'b1;
      idle_gap(gap_odds);
      f = ($urandom_range(1, 100) <= release_pct) ? FUNC_RELEASE : FUNC_ALLOCATE;
      send(f, pick_id());
    end

    drain_wait();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: ends the run if no transaction moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

endmodule

@@ sorted_free_id_pool_core.f @@
sv/sfip_pkg.sv
sv/sfip_mem.sv
sv/sorted_free_id_pool_core.sv
test/sorted_free_id_pool_checker.sv
test/sorted_free_id_pool_core_tb.sv
